// ----- rtl/core/spq_pkg.sv -----
// Package for the stable priority queue: depth, transaction types, codes.
// No dependencies; imported by every module in rtl/core.
package spq_pkg;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE       = 2'd0,
    ST_FULL_DROP  = 2'd1,
    ST_EMPTY_IGN  = 2'd2
  } status_t;

  localparam logic [31:0] EMPTY_MARK = 32'hFFFF_FFFF;

  typedef struct packed {
    op_t                operation;
    logic signed [31:0] item_value;
    logic signed [31:0] item_priority;
  } in_t;

  typedef struct packed {
    logic signed [31:0] head_value;
    logic signed [31:0] head_priority;
    logic               is_empty;
    logic               is_full;
    status_t            status;
  } out_t;

  typedef struct packed {
    logic signed [31:0] ent_value;
    logic signed [31:0] ent_prio;
  } entry_t;

  // broadcast to every cell of the row
  typedef struct packed {
    logic   ins_en;
    logic   rem_en;
    entry_t new_ent;
  } cell_cmd_t;

endpackage

// ----- rtl/core/spq_cell.sv -----
// One compare-and-shift cell of the sorted row.
// Depends on spq_pkg (entry_t, cell_cmd_t).
module spq_cell
  import spq_pkg::*;
(
  input  logic      clk,
  input  cell_cmd_t cmd,
  input  logic      slot_valid,
  input  entry_t    left_ent,
  input  logic      left_ge,
  input  entry_t    right_ent,
  output entry_t    ent_q,
  output entry_t    ent_nxt,
  output logic      ge
);

  entry_t ent_r;

  // stays put on insert: occupied and priority >= new one (FIFO among equals)
  assign ge = slot_valid && !(ent_r.ent_prio < cmd.new_ent.ent_prio);

  always_comb begin
    ent_nxt = ent_r;
    if (cmd.ins_en) begin
      if (!ge) begin
        ent_nxt = left_ge ? cmd.new_ent : left_ent;
      end
    end else if (cmd.rem_en) begin
      ent_nxt = right_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent_q = ent_r;

endmodule

// ----- rtl/core/stable_priority_queue.sv -----
// Stable priority queue: row of DEPTH compare-and-shift cells, head in cell 0.
// An accepted input transaction's result lands in the output register in the following cycle.
// Throughput 1 transaction per cycle while in_stall is low; the whole row updates at once.
// Reset (rst_n low, synchronous) empties the queue and clears out_valid.
// Cell contents are not reset; slots at or beyond the count are never shown.
module stable_priority_queue
  import spq_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  // control
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_data_r, out_data_nxt;
  logic             accept;
  logic             is_ins, ins_ok, rem_ok;
  cell_cmd_t        cmd;

  // row wiring, each element tied to its own cell
  entry_t ent_q   [DEPTH];
  entry_t ent_nxt [DEPTH];
  logic   ge      [DEPTH];

  // a new transaction enters while the result register is free or draining
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign is_ins = (in_data.operation == OP_INSERT);
  assign ins_ok = accept && is_ins && (count_r != CNT_FULL);
  assign rem_ok = accept && !is_ins && (count_r != '0);

  always_comb begin
    cmd.ins_en          = ins_ok;
    cmd.rem_en          = rem_ok;
    cmd.new_ent.ent_value = in_data.item_value;
    cmd.new_ent.ent_prio  = in_data.item_priority;
  end

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      entry_t left_ent, right_ent;
      logic   left_ge;
      if (gi == 0) begin : g_first
        assign left_ent = cmd.new_ent;
        assign left_ge  = 1'b1;   // head cell takes the new entry whenever it does not stay put
      end else begin : g_mid
        assign left_ent = ent_q[gi-1];
        assign left_ge  = ge[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign right_ent = ent_q[gi];  // vacated on remove; never read
      end else begin : g_inner
        assign right_ent = ent_q[gi+1];
      end

      spq_cell u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .slot_valid (CNT_W'(gi) < count_r),
        .left_ent   (left_ent),
        .left_ge    (left_ge),
        .right_ent  (right_ent),
        .ent_q      (ent_q[gi]),
        .ent_nxt    (ent_nxt[gi]),
        .ge         (ge[gi])
      );
    end
  endgenerate

  // occupancy and result
  always_comb begin
    count_nxt = count_r;
    if (ins_ok) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (rem_ok) begin
      count_nxt = count_r - CNT_W'(1);
    end

    out_data_nxt = out_data_r;
    if (accept) begin
      if (count_nxt == '0) begin
        out_data_nxt.head_value    = EMPTY_MARK;
        out_data_nxt.head_priority = EMPTY_MARK;
      end else begin
        out_data_nxt.head_value    = ent_nxt[0].ent_value;
        out_data_nxt.head_priority = ent_nxt[0].ent_prio;
      end
      out_data_nxt.is_empty = (count_nxt == '0);
      out_data_nxt.is_full  = (count_nxt == CNT_FULL);
      priority if (is_ins && !ins_ok) begin
        out_data_nxt.status = ST_FULL_DROP;
      end else if (!is_ins && !rem_ok) begin
        out_data_nxt.status = ST_EMPTY_IGN;
      end else begin
        out_data_nxt.status = ST_DONE;
      end
    end

    out_valid_nxt = accept ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // occupancy never passes the row length
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("occupancy above depth");

  // an accepted transaction always leaves a result behind
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted transaction gave no result");

  // a dropped insert only happens on a full queue, and reports it full
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_ins && !ins_ok) |=> (out_data_r.is_full && count_r == CNT_FULL))
    else $error("insert dropped on a queue that was not full");

  // empty result carries the empty mark in both head fields
  a_empty_mark: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.is_empty) |->
      (out_data_r.head_value == EMPTY_MARK && out_data_r.head_priority == EMPTY_MARK))
    else $error("empty result without empty mark");

endmodule
